[src/hkr_pkg.sv]
// Package for the I2C housekeeping responder: item and result types,
// bus event codes, command codes and reply bytes. No dependencies.
package hkr_pkg;

  localparam int HK_COUNT = 6;
  localparam int IDX_W = 3;

  localparam logic [2:0] EV_ADDR_WRITE = 3'd0;
  localparam logic [2:0] EV_DATA_RX    = 3'd1;
  localparam logic [2:0] EV_ADDR_READ  = 3'd2;
  localparam logic [2:0] EV_DATA_SENT  = 3'd3;

  localparam logic [7:0] CMD_START   = 8'h02;
  localparam logic [7:0] CMD_READ_ID = 8'h10;
  localparam logic [7:0] REPLY_ID    = 8'h0F;
  localparam logic [7:0] REPLY_START = 8'h03;
  localparam logic [7:0] END_MARKER  = 8'h05;

  localparam logic [7:0] PORT_BURNER  = 8'h10;
  localparam logic [7:0] PORT_COLLECT = 8'h80;

  localparam logic [1:0] PHASE_CLEAR = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [2:0] bus_event;
    logic [7:0] rx_byte;
    logic [7:0] port_a_pins;
    logic [7:0] adc_sample_0;
    logic [7:0] adc_sample_1;
    logic [7:0] adc_sample_5;
    logic [7:0] adc_sample_6;
    logic [7:0] adc_sample_7;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       release_bus;
    logic [7:0] port_b_out;
  } result_t;

endpackage

[src/i2c_housekeeping_responder.sv]
// Top level of the I2C housekeeping responder.
// Depends on hkr_pkg, hkr_in_stage, hkr_core and hkr_out_stage.
//
// Each input transaction is either a bus event from the I2C slave
// interface or a periodic timer tick, and yields exactly one result
// transaction: an optional byte to transmit, a bus release flag and the
// current output port value.
// Both channels use valid and ready. An accepted item sits in the input
// register; once the result register is free it passes through the command
// logic into the result register, where the result is presented until the
// receiver takes it.
// One item per cycle is sustained while the receiver is ready, with the
// single command and tick update made as each item leaves the input register.
// When the receiver stalls, the result register holds its transaction
// and the input register takes one more item; ready falls only when both
// are full. Reset empties both registers and clears the stored command, the
// stream index, the tick sequencer and the port. The housekeeping bytes hold
// no value until the first collecting tick.
module i2c_housekeeping_responder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [2:0] in_bus_event,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_adc_sample_0,
  input  logic [7:0] in_adc_sample_1,
  input  logic [7:0] in_adc_sample_5,
  input  logic [7:0] in_adc_sample_6,
  input  logic [7:0] in_adc_sample_7,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_release_bus,
  output logic [7:0] out_port_b_out
);

  hkr_pkg::item_t   in_item;
  hkr_pkg::item_t   item;
  hkr_pkg::result_t result;
  hkr_pkg::result_t out_result;
  logic             item_valid;
  logic             free;
  logic             fire;

  assign in_item.operation    = in_operation;
  assign in_item.bus_event    = in_bus_event;
  assign in_item.rx_byte      = in_rx_byte;
  assign in_item.port_a_pins  = in_port_a_pins;
  assign in_item.adc_sample_0 = in_adc_sample_0;
  assign in_item.adc_sample_1 = in_adc_sample_1;
  assign in_item.adc_sample_5 = in_adc_sample_5;
  assign in_item.adc_sample_6 = in_adc_sample_6;
  assign in_item.adc_sample_7 = in_adc_sample_7;

  assign fire = item_valid && free;

  hkr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hkr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  hkr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_tx_valid    = out_result.tx_valid;
  assign out_tx_byte     = out_result.tx_byte;
  assign out_release_bus = out_result.release_bus;
  assign out_port_b_out  = out_result.port_b_out;

endmodule

[src/hkr_in_stage.sv]
// Input register of the housekeeping responder: holds one accepted item
// until the core can take it. Depends on hkr_pkg.
module hkr_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hkr_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output hkr_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  hkr_pkg::item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[src/hkr_core.sv]
// Command and tick handling of the housekeeping responder: holds the
// command, stream index, housekeeping bytes, tick phase and port value.
// Depends on hkr_pkg.
module hkr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  hkr_pkg::item_t   item,
  output hkr_pkg::result_t result
);

  logic [7:0]                 cmd_r, cmd_nxt;
  logic [hkr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic                       ticking_r, ticking_nxt;
  logic [7:0]                 port_r, port_nxt;
  logic [7:0]                 hk_r [hkr_pkg::HK_COUNT];
  logic                       collect;

  always_comb begin
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    phase_nxt   = phase_r;
    ticking_nxt = ticking_r;
    port_nxt    = port_r;
    collect     = 1'b0;
    result      = '0;
    if (item.operation) begin
      if (ticking_r) begin
        if (phase_r < hkr_pkg::PHASE_CLEAR) begin
          collect   = 1'b1;
          port_nxt  = port_r | hkr_pkg::PORT_COLLECT;
          phase_nxt = phase_r + 2'd1;
        end else begin
          port_nxt  = '0;
          phase_nxt = '0;
        end
      end
    end else begin
      case (item.bus_event)
        hkr_pkg::EV_DATA_RX: begin
          cmd_nxt = item.rx_byte;
          if (item.rx_byte == hkr_pkg::CMD_START) begin
            port_nxt    = port_r | hkr_pkg::PORT_BURNER;
            ticking_nxt = 1'b1;
          end
          result.release_bus = 1'b1;
        end
        hkr_pkg::EV_ADDR_READ: begin
          if (cmd_r == hkr_pkg::CMD_READ_ID) begin
            result.tx_valid    = 1'b1;
            result.tx_byte     = hkr_pkg::REPLY_ID;
            result.release_bus = 1'b1;
          end else if (cmd_r == hkr_pkg::CMD_START) begin
            result.tx_valid    = 1'b1;
            result.tx_byte     = hkr_pkg::REPLY_START;
            result.release_bus = 1'b1;
          end
        end
        hkr_pkg::EV_DATA_SENT: begin
          result.tx_valid    = 1'b1;
          result.release_bus = 1'b1;
          if (idx_r < hkr_pkg::IDX_W'(hkr_pkg::HK_COUNT)) begin
            result.tx_byte = hk_r[idx_r];
            idx_nxt        = idx_r + 1'b1;
          end else begin
            result.tx_byte = hkr_pkg::END_MARKER;
            idx_nxt        = '0;
            port_nxt       = hkr_pkg::PORT_BURNER;
          end
        end
        default: begin
          result.release_bus = 1'b1;
        end
      endcase
    end
    result.port_b_out = port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= '0;
      idx_r     <= '0;
      phase_r   <= '0;
      ticking_r <= 1'b0;
      port_r    <= '0;
    end else if (fire) begin
      cmd_r     <= cmd_nxt;
      idx_r     <= idx_nxt;
      phase_r   <= phase_nxt;
      ticking_r <= ticking_nxt;
      port_r    <= port_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && collect) begin
      hk_r[0] <= {1'b0, item.port_a_pins[7], 1'b0, item.port_a_pins[6],
                  1'b0, item.port_a_pins[5], 1'b0, item.port_a_pins[3]};
      hk_r[1] <= item.adc_sample_0;
      hk_r[2] <= item.adc_sample_1;
      hk_r[3] <= item.adc_sample_5;
      hk_r[4] <= item.adc_sample_6;
      hk_r[5] <= item.adc_sample_7;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= hkr_pkg::IDX_W'(hkr_pkg::HK_COUNT))
    else $error("stream index beyond the end marker");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= hkr_pkg::PHASE_CLEAR)
    else $error("tick phase left the three-phase cycle");

  a_clear_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.operation && ticking_r && phase_r == hkr_pkg::PHASE_CLEAR
    |=> port_r == '0 && phase_r == '0)
    else $error("clearing tick did not clear the port");

  a_start_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.operation && item.bus_event == hkr_pkg::EV_DATA_RX &&
    item.rx_byte == hkr_pkg::CMD_START |=> ticking_r && port_r[4])
    else $error("start command did not start the sequencer");

endmodule

[src/hkr_out_stage.sv]
// Result register of the housekeeping responder: holds one result until
// the receiver takes it. Depends on hkr_pkg.
module hkr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hkr_pkg::result_t result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output hkr_pkg::result_t out_result
);

  logic             valid_r;
  logic             valid_nxt;
  hkr_pkg::result_t result_r;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

[tb/i2c_housekeeping_responder_tb.sv]
// Self-checking testbench for i2c_housekeeping_responder: a directed table and then random
// command, read, stream and tick sequences, checked against typed rows or a behavioural predictor.
// Depends on hkr_pkg and the responder RTL.
module i2c_housekeeping_responder_tb;

  localparam logic [2:0] EV_OTHER   = 3'd4;
  localparam logic [2:0] EV_RSVD_LO = 3'd5;
  localparam logic [2:0] EV_RSVD_HI = 3'd7;
  localparam int RAND_ITEMS  = 1430;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    hkr_pkg::item_t   it;
    bit               typed;
    hkr_pkg::result_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [2:0] in_bus_event;
  logic [7:0] in_rx_byte;
  logic [7:0] in_port_a_pins;
  logic [7:0] in_adc_sample_0;
  logic [7:0] in_adc_sample_1;
  logic [7:0] in_adc_sample_5;
  logic [7:0] in_adc_sample_6;
  logic [7:0] in_adc_sample_7;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_release_bus;
  logic [7:0] out_port_b_out;

  i2c_housekeeping_responder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_bus_event    (in_bus_event),
    .in_rx_byte      (in_rx_byte),
    .in_port_a_pins  (in_port_a_pins),
    .in_adc_sample_0 (in_adc_sample_0),
    .in_adc_sample_1 (in_adc_sample_1),
    .in_adc_sample_5 (in_adc_sample_5),
    .in_adc_sample_6 (in_adc_sample_6),
    .in_adc_sample_7 (in_adc_sample_7),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_valid    (out_tx_valid),
    .out_tx_byte     (out_tx_byte),
    .out_release_bus (out_release_bus),
    .out_port_b_out  (out_port_b_out)
  );

  always #6 clk = ~clk;

  // Predicted responder state.
  logic [7:0] cmd_q;
  logic [2:0] idx_q;
  logic [7:0] hk_q [hkr_pkg::HK_COUNT];
  logic [1:0] phase_q;
  bit         tick_on;
  logic [7:0] port_q;
  bit         hk_filled;

  hkr_pkg::result_t hk_expected [$];
  dir_row_t         dir_rows [$];
  int               fails = 0;
  int               sent_count = 0;
  int               results_checked = 0;
  int               collect_ticks = 0;
  int               bytes_streamed = 0;
  int               burst_left = 0;
  int               hold_asks = 0;
  int               hold_done = 0;
  int               hold_left = 0;
  int               rx_cycle = 0;
  int               cycles = 0;

  function automatic hkr_pkg::result_t hk_predict(input hkr_pkg::item_t it);
    hkr_pkg::result_t r;
    r = '0;
    if (it.operation) begin
      if (tick_on) begin
        if (phase_q < hkr_pkg::PHASE_CLEAR) begin
          hk_q[0] = {1'b0, it.port_a_pins[7], 1'b0, it.port_a_pins[6],
                     1'b0, it.port_a_pins[5], 1'b0, it.port_a_pins[3]};
          hk_q[1] = it.adc_sample_0;
          hk_q[2] = it.adc_sample_1;
          hk_q[3] = it.adc_sample_5;
          hk_q[4] = it.adc_sample_6;
          hk_q[5] = it.adc_sample_7;
          hk_filled = 1'b1;
          collect_ticks++;
          port_q = port_q | hkr_pkg::PORT_COLLECT;
          phase_q = phase_q + 2'd1;
        end else begin
          port_q = '0;
          phase_q = '0;
        end
      end
    end else begin
      case (it.bus_event)
        hkr_pkg::EV_DATA_RX: begin
          cmd_q = it.rx_byte;
          if (it.rx_byte == hkr_pkg::CMD_START) begin
            port_q = port_q | hkr_pkg::PORT_BURNER;
            tick_on = 1'b1;
          end
          r.release_bus = 1'b1;
        end
        hkr_pkg::EV_ADDR_READ: begin
          if (cmd_q == hkr_pkg::CMD_READ_ID) begin
            r.tx_valid = 1'b1;
            r.tx_byte = hkr_pkg::REPLY_ID;
            r.release_bus = 1'b1;
          end else if (cmd_q == hkr_pkg::CMD_START) begin
            r.tx_valid = 1'b1;
            r.tx_byte = hkr_pkg::REPLY_START;
            r.release_bus = 1'b1;
          end
        end
        hkr_pkg::EV_DATA_SENT: begin
          r.tx_valid = 1'b1;
          if (idx_q < hkr_pkg::HK_COUNT) begin
            r.tx_byte = hk_q[idx_q];
            idx_q = idx_q + 3'd1;
          end else begin
            r.tx_byte = hkr_pkg::END_MARKER;
            idx_q = '0;
            port_q = hkr_pkg::PORT_BURNER;
          end
          bytes_streamed++;
          r.release_bus = 1'b1;
        end
        default: r.release_bus = 1'b1;
      endcase
    end
    r.port_b_out = port_q;
    return r;
  endfunction

  function automatic hkr_pkg::item_t mk_bus(input logic [2:0] ev, input logic [7:0] rx);
    hkr_pkg::item_t it;
    it = '0;
    it.bus_event = ev;
    it.rx_byte = rx;
    return it;
  endfunction

  function automatic hkr_pkg::item_t mk_tick(input logic [7:0] pins, input logic [7:0] a0,
                                             input logic [7:0] a1, input logic [7:0] a5,
                                             input logic [7:0] a6, input logic [7:0] a7);
    hkr_pkg::item_t it;
    it = '0;
    it.operation = 1'b1;
    it.port_a_pins = pins;
    it.adc_sample_0 = a0;
    it.adc_sample_1 = a1;
    it.adc_sample_5 = a5;
    it.adc_sample_6 = a6;
    it.adc_sample_7 = a7;
    return it;
  endfunction

  function automatic hkr_pkg::item_t rand_fill(input logic op, input logic [2:0] ev,
                                               input logic [7:0] rx);
    hkr_pkg::item_t it;
    it = mk_tick(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    it.operation = op;
    it.bus_event = ev;
    it.rx_byte = rx;
    return it;
  endfunction

  function automatic hkr_pkg::result_t mk_res(input logic tv, input logic [7:0] tb,
                                              input logic rel, input logic [7:0] port);
    hkr_pkg::result_t r;
    r.tx_valid = tv;
    r.tx_byte = tb;
    r.release_bus = rel;
    r.port_b_out = port;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input hkr_pkg::item_t it, input bit typed,
                                      input hkr_pkg::result_t res);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction was accepted.
  task automatic send_txn(input hkr_pkg::item_t it_in, input bit typed,
                          input hkr_pkg::result_t typed_res);
    hkr_pkg::item_t   it;
    hkr_pkg::result_t pred;
    int               gap;
    it = it_in;
    // Streaming before the first collecting tick would read unwritten housekeeping bytes.
    if (!it.operation && it.bus_event == hkr_pkg::EV_DATA_SENT && !hk_filled)
      it.bus_event = EV_OTHER;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_operation    <= it.operation;
    in_bus_event    <= it.bus_event;
    in_rx_byte      <= it.rx_byte;
    in_port_a_pins  <= it.port_a_pins;
    in_adc_sample_0 <= it.adc_sample_0;
    in_adc_sample_1 <= it.adc_sample_1;
    in_adc_sample_5 <= it.adc_sample_5;
    in_adc_sample_6 <= it.adc_sample_6;
    in_adc_sample_7 <= it.adc_sample_7;
    do @(posedge clk); while (!in_ready);
    pred = hk_predict(it);
    hk_expected.push_back(typed ? typed_res : pred);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (hk_expected.size() != 0);
  endtask

  initial begin
    int               kind;
    int               n;
    hkr_pkg::result_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_bus_event = '0;
    in_rx_byte = '0;
    in_port_a_pins = '0;
    in_adc_sample_0 = '0;
    in_adc_sample_1 = '0;
    in_adc_sample_5 = '0;
    in_adc_sample_6 = '0;
    in_adc_sample_7 = '0;
    cmd_q = '0;
    idx_q = '0;
    phase_q = '0;
    tick_on = 1'b0;
    port_q = '0;
    hk_filled = 1'b0;
    foreach (hk_q[i]) hk_q[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(mk_row(mk_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_ADDR_READ, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_ADDR_WRITE, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_RX, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(EV_OTHER, 8'hFF), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(EV_RSVD_LO, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(EV_RSVD_LO + 3'd1, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(EV_RSVD_HI, 8'hFF), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_RX, hkr_pkg::CMD_READ_ID), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_ADDR_READ, 8'h00), 1'b1,
                              mk_res(1'b1, hkr_pkg::REPLY_ID, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_RX, 8'hFF), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_ADDR_READ, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_RX, hkr_pkg::CMD_START), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1, hkr_pkg::PORT_BURNER)));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_ADDR_READ, 8'h00), 1'b1,
                              mk_res(1'b1, hkr_pkg::REPLY_START, 1'b1,
                                     hkr_pkg::PORT_BURNER)));
    dir_rows.push_back(mk_row(mk_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0,
                                     hkr_pkg::PORT_BURNER | hkr_pkg::PORT_COLLECT)));
    dir_rows.push_back(mk_row(mk_tick(8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A), 1'b0,
                              none));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_RX, hkr_pkg::CMD_START), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b1,
                                     hkr_pkg::PORT_BURNER | hkr_pkg::PORT_COLLECT)));
    repeat (hkr_pkg::HK_COUNT)
      dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_SENT, 8'h00), 1'b0, none));
    dir_rows.push_back(mk_row(mk_bus(hkr_pkg::EV_DATA_SENT, 8'h00), 1'b1,
                              mk_res(1'b1, hkr_pkg::END_MARKER, 1'b1,
                                     hkr_pkg::PORT_BURNER)));
    dir_rows.push_back(mk_row(mk_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                              mk_res(1'b0, 8'h00, 1'b0, hkr_pkg::PORT_COLLECT)));

    foreach (dir_rows[i]) send_txn(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    n = sent_count + RAND_ITEMS;
    while (sent_count < n) begin
      if (hold_asks < 3 && sent_count >= 400 * (hold_asks + 1)) hold_asks++;
      if (sent_count >= 900 && sent_count < 910) drain_results();
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        send_txn(rand_fill(1'b0, hkr_pkg::EV_ADDR_WRITE, 8'($urandom)), 1'b0, none);
        case ($urandom_range(0, 3))
          0:       send_txn(rand_fill(1'b0, hkr_pkg::EV_DATA_RX, hkr_pkg::CMD_START),
                            1'b0, none);
          1, 3:    send_txn(rand_fill(1'b0, hkr_pkg::EV_DATA_RX, hkr_pkg::CMD_READ_ID),
                            1'b0, none);
          default: send_txn(rand_fill(1'b0, hkr_pkg::EV_DATA_RX, 8'($urandom)),
                            1'b0, none);
        endcase
      end else if (kind <= 4) begin
        send_txn(rand_fill(1'b0, hkr_pkg::EV_ADDR_READ, 8'($urandom)), 1'b0, none);
        repeat ($urandom_range(1, 8))
          send_txn(rand_fill(1'b0, hkr_pkg::EV_DATA_SENT, 8'($urandom)), 1'b0, none);
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 3))
          send_txn(rand_fill(1'b1, 3'($urandom_range(0, 7)), 8'($urandom)), 1'b0, none);
      end else if (kind == 8) begin
        send_txn(rand_fill(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                           8'($urandom)), 1'b0, none);
      end else begin
        repeat ($urandom_range(2, 4))
          send_txn(rand_fill(1'b0, 3'($urandom_range(0, 4)), 8'($urandom)), 1'b0, none);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d transactions: %0d collecting ticks, %0d bytes streamed.",
             sent_count, collect_ticks, bytes_streamed);
    $display("%0d results checked, %0d long receiver hold-offs.", results_checked, hold_done);
    if (fails == 0 && hk_expected.size() == 0) begin
      $display("i2c_housekeeping_responder_tb passed");
    end else begin
      $display("i2c_housekeeping_responder_tb failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asks;
    end else begin
      case (rx_cycle[8:6])
        3'd2:    out_ready <= ($urandom_range(0, 3) != 0);
        3'd3:    out_ready <= (rx_cycle[1:0] != 2'd0);
        3'd4:    out_ready <= 1'($urandom_range(0, 1));
        3'd5:    out_ready <= rx_cycle[2];
        3'd6:    out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    hkr_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hk_expected.size() == 0) begin
        $error("Result transaction arrived with no expectation waiting.");
        fails++;
      end else begin
        want = hk_expected.pop_front();
        results_checked++;
        if (out_tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %0d, got %0d", want.tx_valid, out_tx_valid);
          fails++;
        end
        if (out_tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, out_tx_byte);
          fails++;
        end
        if (out_release_bus !== want.release_bus) begin
          $error("release_bus: expected %0d, got %0d", want.release_bus, out_release_bus);
          fails++;
        end
        if (out_port_b_out !== want.port_b_out) begin
          $error("port_b_out: expected 0x%02h, got 0x%02h", want.port_b_out, out_port_b_out);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_housekeeping_responder_tb failed");
      $finish;
    end
  end

endmodule

[filelist.f]
src/hkr_pkg.sv
src/hkr_in_stage.sv
src/hkr_core.sv
src/hkr_out_stage.sv
src/i2c_housekeeping_responder.sv
tb/i2c_housekeeping_responder_tb.sv
